### hdl/bssr_pkg.sv
// Shared types and constants for the bad sector skip remap block.
package bssr_pkg;

  localparam int unsigned TABLE_DEPTH = 2048;
  localparam int unsigned ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int unsigned SECTOR_W    = 32;
  localparam int unsigned MAPPED_W    = 33;
  localparam int unsigned BAD_COUNT_W = 12;

  localparam int unsigned S_TDATA_W   = 32;
  localparam int unsigned M_TDATA_W   = 48;

  localparam logic CMD_REGISTER  = 1'b0;
  localparam logic CMD_TRANSLATE = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

### hdl/bad_sector_skip_remap.sv
// Bad sector table with skip-style logical to physical sector translation.
//
// A register beat (tuser = 0) appends the sector to the table while it has
// room and answers in the next cycle; when the table is full it answers with
// status set and leaves the table alone. A translate beat (tuser = 1) walks
// the stored entries in insertion order through the table's single read
// port, one entry per cycle, and bumps the running sector for every entry
// not above it. A translate answers from ST_WALK once the last stored entry
// is checked, or in the next cycle without a walk when the table is empty;
// the input is not ready while a walk is in progress or a result is stalled.
module bad_sector_skip_remap (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bssr_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [31:0] sector
  input  logic                           s_axis_tuser,  // [0] cmd

  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [bssr_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [32:0] mapped_sector,
                                                        // [44:33] bad_count, [47:45] zero
  output logic                           m_axis_tuser   // [0] status
);

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e state_q;

  logic [bssr_pkg::CNT_W-1:0]       count_q;
  logic [bssr_pkg::CNT_W-1:0]       idx_q;
  logic [bssr_pkg::MAPPED_W-1:0]    run_q;

  logic                             out_valid_q;
  logic [bssr_pkg::MAPPED_W-1:0]    out_mapped_q;
  logic [bssr_pkg::CNT_W-1:0]       out_count_q;
  logic                             out_status_q;

  logic [bssr_pkg::SECTOR_W-1:0]    mem [bssr_pkg::TABLE_DEPTH];
  logic [bssr_pkg::SECTOR_W-1:0]    rd_data_q;
  logic [bssr_pkg::ADDR_W-1:0]      rd_addr;

  logic                             accept;
  logic                             full;
  logic                             wr_en;
  logic [bssr_pkg::SECTOR_W-1:0]    sector;
  logic                             hit;
  logic [bssr_pkg::MAPPED_W-1:0]    run_nxt;
  logic                             last;

  assign sector  = s_axis_tdata[bssr_pkg::SECTOR_W-1:0];
  assign full    = (count_q == bssr_pkg::CNT_W'(bssr_pkg::TABLE_DEPTH));

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign wr_en         = accept && (s_axis_tuser == bssr_pkg::CMD_REGISTER) && !full;

  assign rd_addr = (state_q == ST_WALK) ? idx_q[bssr_pkg::ADDR_W-1:0] : '0;

  assign hit     = ({1'b0, rd_data_q} <= run_q);
  assign run_nxt = hit ? run_q + bssr_pkg::MAPPED_W'(1) : run_q;
  assign last    = (idx_q == count_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[bssr_pkg::ADDR_W-1:0]] <= sector;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      idx_q        <= '0;
      run_q        <= '0;
      out_valid_q  <= 1'b0;
      out_mapped_q <= '0;
      out_count_q  <= '0;
      out_status_q <= bssr_pkg::STATUS_OK;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (s_axis_tuser == bssr_pkg::CMD_REGISTER) begin
              out_valid_q  <= 1'b1;
              out_mapped_q <= {1'b0, sector};
              if (full) begin
                out_count_q  <= count_q;
                out_status_q <= bssr_pkg::STATUS_FULL;
              end else begin
                count_q      <= count_q + bssr_pkg::CNT_W'(1);
                out_count_q  <= count_q + bssr_pkg::CNT_W'(1);
                out_status_q <= bssr_pkg::STATUS_OK;
              end
            end else if (count_q == '0) begin
              out_valid_q  <= 1'b1;
              out_mapped_q <= {1'b0, sector};
              out_count_q  <= count_q;
              out_status_q <= bssr_pkg::STATUS_OK;
            end else begin
              run_q   <= {1'b0, sector};
              idx_q   <= bssr_pkg::CNT_W'(1);
              state_q <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (last) begin
            out_valid_q  <= 1'b1;
            out_mapped_q <= run_nxt;
            out_count_q  <= count_q;
            out_status_q <= bssr_pkg::STATUS_OK;
            state_q      <= ST_IDLE;
          end else begin
            run_q <= run_nxt;
            idx_q <= idx_q + bssr_pkg::CNT_W'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, bssr_pkg::BAD_COUNT_W'(out_count_q), out_mapped_q};
  assign m_axis_tuser  = out_status_q;

endmodule

### hdl/bssr_checker.sv
// Port-level checker for the bad sector skip remap block, with its bind.
module bssr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [bssr_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [bssr_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);

  localparam logic [bssr_pkg::BAD_COUNT_W-1:0] FULL_COUNT =
    bssr_pkg::BAD_COUNT_W'(bssr_pkg::TABLE_DEPTH);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  a_register_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == bssr_pkg::CMD_REGISTER) |=>
      m_axis_tvalid && (m_axis_tdata[31:0] == $past(s_axis_tdata[31:0]))
      && !m_axis_tdata[32])
    else $error("register beat not echoed on the next cycle");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == bssr_pkg::STATUS_FULL) |->
      (m_axis_tdata[44:33] == FULL_COUNT))
    else $error("full status with table not full");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[44:33] <= FULL_COUNT))
    else $error("bad count above table depth");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == bssr_pkg::CMD_TRANSLATE)
      && m_axis_tvalid && m_axis_tready && (m_axis_tdata[44:33] != 12'd0) |=>
      !s_axis_tready)
    else $error("input ready during a table walk");

endmodule

bind bad_sector_skip_remap bssr_checker u_bssr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
